// ----- src/grd_pkg.sv -----
// shared constants, codes and types of the graph reachability block
// no dependencies; compile first
package grd_pkg;

   localparam int DEF_MAX_NODES = 1024;
   localparam int DEF_MAX_EDGES = 2048;

   localparam int OP_W       = 2;
   localparam int NODE_W     = 10;
   localparam int NCOUNT_W   = 11;
   localparam int STATUS_W   = 2;
   localparam int WIDX_W     = 4;
   localparam int WORD_W     = 64;
   localparam int WORD_SHIFT = $clog2(WORD_W);
   localparam int EDGE_W     = 2 * NODE_W;

   localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [EDGE_W-1:0] edge_type;

endpackage

// ----- src/grd_ifs.sv -----
// valid/ready channel interfaces: request, response and register write
// depends on grd_pkg
interface grd_req_if;
   import grd_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   node_type          end_a;
   node_type          end_b;
   node_type          start_node;
   modport source (output valid, operation, end_a, end_b, start_node, input ready);
   modport sink   (input valid, operation, end_a, end_b, start_node, output ready);
endinterface

interface grd_rsp_if;
   import grd_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [WIDX_W-1:0]   word_index;
   word_type            reached_bits;
   logic                last;
   modport source (output valid, status, word_index, reached_bits, last, input ready);
   modport sink   (input valid, status, word_index, reached_bits, last, output ready);
endinterface

interface grd_csr_if;
   import grd_pkg::*;
   logic                valid;
   logic                ready;
   logic [NCOUNT_W-1:0] node_count;
   modport source (output valid, node_count, input ready);
   modport sink   (input valid, node_count, output ready);
endinterface

// ----- src/grd_edge_store.sv -----
// edge list memory: one write port, one registered read port
// depends on grd_pkg
module grd_edge_store #(
   parameter int DEPTH = grd_pkg::DEF_MAX_EDGES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  grd_pkg::edge_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output grd_pkg::edge_type        rd_data
);
   import grd_pkg::*;

   edge_type mem_ff [DEPTH];
   edge_type rd_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_q_ff;

endmodule

// ----- src/grd_stack.sv -----
// pending-node stack memory: one write port, one registered read port
// depends on grd_pkg
module grd_stack #(
   parameter int DEPTH = grd_pkg::DEF_MAX_NODES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  grd_pkg::node_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output grd_pkg::node_type        rd_data
);
   import grd_pkg::*;

   node_type mem_ff [DEPTH];
   node_type rd_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_q_ff;

endmodule

// ----- src/grd_visit_map.sv -----
// visited bitmap, 64 nodes per row, with write-to-read bypass
// depends on grd_pkg
module grd_visit_map #(
   parameter int ROWS = grd_pkg::DEF_MAX_NODES / grd_pkg::WORD_W,
   localparam int AW  = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  grd_pkg::word_type wr_data,
   input  logic [AW-1:0]     rd_addr,
   output grd_pkg::word_type rd_data
);
   import grd_pkg::*;

   word_type mem_ff [ROWS];
   word_type rd_q_ff;
   word_type byp_data_ff;
   logic     byp_hit_ff;

   // a read that meets a write to the same row returns the new row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_q_ff     <= mem_ff[rd_addr];
      byp_hit_ff  <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= wr_data;
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : rd_q_ff;

endmodule

// ----- src/graph_reachability_dfs_top.sv -----
// top level of the graph reachability block: sequencer, edge sweep pipeline, output register
// depends on grd_pkg, grd_ifs, grd_edge_store, grd_stack, grd_visit_map
//
//   port     dir   what moves in one transfer
//   -------  ----  ------------------------------------------------------
//   req_ch   in    operation, end_a, end_b, start_node (clear/append/search)
//   rsp_ch   out   status, word_index, reached_bits, last
//   csr_ch   in    node_count (single register, accepted every cycle)
//
// clear and append pass through S_RESULT to a registered response
// a search clears the visited rows (S_CLEAR), seeds the start node (S_SEED), then for
// each reached node pops it (S_POP), reads it off the stack (S_CUR) and sweeps the edge
// list with one edge-store read per cycle until the pipe drains; with an empty list S_CUR
// goes straight back to S_POP; after the final empty pop each output word is read
// (S_OUT_RD) and sent (S_OUT_WR)
// one request is in work at a time; a held response does not block the next request
// reset is synchronous; it needs no clearing pass, the visited rows are cleared per search
module graph_reachability_dfs_top #(
   parameter int MAX_NODES = grd_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = grd_pkg::DEF_MAX_EDGES
) (
   input  logic      clock,
   input  logic      reset,
   grd_req_if.sink   req_ch,
   grd_rsp_if.source rsp_ch,
   grd_csr_if.sink   csr_ch
);
   import grd_pkg::*;

   localparam int ROWS = (MAX_NODES + WORD_W - 1) / WORD_W;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int EA_W = $clog2(MAX_EDGES);
   localparam int ET_W = $clog2(MAX_EDGES + 1);
   localparam int SA_W = $clog2(MAX_NODES);
   localparam int SD_W = $clog2(MAX_NODES + 1);
   localparam int XW   = (RW + WORD_SHIFT + 1 > NCOUNT_W + 1) ? RW + WORD_SHIFT + 1
                                                             : NCOUNT_W + 1;

   // sequencer states
   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
   localparam logic [STATE_W-1:0] S_RESULT = 4'd1;
   localparam logic [STATE_W-1:0] S_CLEAR  = 4'd2;
   localparam logic [STATE_W-1:0] S_SEED   = 4'd3;
   localparam logic [STATE_W-1:0] S_POP    = 4'd4;
   localparam logic [STATE_W-1:0] S_CUR    = 4'd5;
   localparam logic [STATE_W-1:0] S_SWEEP  = 4'd6;
   localparam logic [STATE_W-1:0] S_OUT_RD = 4'd7;
   localparam logic [STATE_W-1:0] S_OUT_WR = 4'd8;

   logic [STATE_W-1:0]  state_ff, state_in;
   logic [NCOUNT_W-1:0] node_count_ff, node_count_in;
   logic [ET_W-1:0]     edge_total_ff, edge_total_in;
   logic [SD_W-1:0]     depth_ff, depth_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   node_type            start_ff, start_in;
   logic [RW-1:0]       row_ff, row_in;
   node_type            cur_ff, cur_in;
   logic [ET_W-1:0]     eidx_ff, eidx_in;
   logic                s1_v_ff, s1_v_in;
   logic                s2_v_ff, s2_v_in;
   node_type            s2_node_ff, s2_node_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [WIDX_W-1:0]   rsp_widx_ff, rsp_widx_in;
   word_type            rsp_bits_ff, rsp_bits_in;
   logic                rsp_last_ff, rsp_last_in;

   // memory ports
   logic            edge_wr_en;
   logic [EA_W-1:0] edge_wr_addr;
   edge_type        edge_wr_data;
   logic [EA_W-1:0] edge_rd_addr;
   edge_type        edge_rd_data;

   logic            vis_wr_en;
   logic [RW-1:0]   vis_wr_addr;
   word_type        vis_wr_data;
   logic [RW-1:0]   vis_rd_addr;
   word_type        vis_rd_data;

   logic            stk_wr_en;
   logic [SA_W-1:0] stk_wr_addr;
   node_type        stk_wr_data;
   logic [SA_W-1:0] stk_rd_addr;
   node_type        stk_rd_data;

   // misc combinational
   logic [NCOUNT_W-1:0]   n_eff;
   logic                  req_fire;
   logic                  csr_fire;
   logic                  out_free;
   logic                  edge_full;
   logic                  issue;
   node_type              e_a, e_b, nbr;
   logic                  e_ok, hit_a, hit_b, cand;
   logic                  s2_bit, push;
   logic [SD_W-1:0]       pop_idx;
   logic [XW-1:0]         word_end;
   logic                  word_last;
   logic [WORD_SHIFT-1:0] tail;
   word_type              tail_mask;

   grd_edge_store #(.DEPTH(MAX_EDGES)) u_edges (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

   grd_visit_map #(.ROWS(ROWS)) u_visit (
      .clock   (clock),
      .wr_en   (vis_wr_en),
      .wr_addr (vis_wr_addr),
      .wr_data (vis_wr_data),
      .rd_addr (vis_rd_addr),
      .rd_data (vis_rd_data)
   );

   grd_stack #(.DEPTH(MAX_NODES)) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // node count in use, saturated to the map size
   assign n_eff = (node_count_ff > MAX_NODES) ? NCOUNT_W'(MAX_NODES) : node_count_ff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign edge_full    = (edge_total_ff == ET_W'(MAX_EDGES));

   // sweep stage 0: issue one edge read per cycle
   assign issue = (state_ff == S_SWEEP) && (eidx_ff < edge_total_ff);

   // sweep stage 1: edge data back, pick the neighbor of the current node
   assign e_a   = edge_rd_data[EDGE_W-1:NODE_W];
   assign e_b   = edge_rd_data[NODE_W-1:0];
   assign e_ok  = (NCOUNT_W'(e_a) < n_eff) && (NCOUNT_W'(e_b) < n_eff);
   assign hit_a = (e_a == cur_ff);
   assign hit_b = (e_b == cur_ff);
   assign nbr   = hit_a ? e_b : e_a;
   assign cand  = s1_v_ff && e_ok && (hit_a || hit_b);

   // sweep stage 2: visited row back, push if the neighbor is new
   assign s2_bit = vis_rd_data[s2_node_ff[WORD_SHIFT-1:0]];
   assign push   = s2_v_ff && !s2_bit && (depth_ff < SD_W'(MAX_NODES));

   assign pop_idx = depth_ff - SD_W'(1);

   // output word bookkeeping
   assign word_end  = (XW'(row_ff) + XW'(1)) << WORD_SHIFT;
   assign word_last = (word_end >= XW'(n_eff));
   assign tail      = n_eff[WORD_SHIFT-1:0];
   assign tail_mask = (word_last && (tail != '0)) ? ((WORD_W'(1) << tail) - WORD_W'(1))
                                                  : {WORD_W{1'b1}};

   always_comb begin
      state_in      = state_ff;
      node_count_in = csr_fire ? csr_ch.node_count : node_count_ff;
      edge_total_in = edge_total_ff;
      depth_in      = depth_ff;
      status_in     = status_ff;
      start_in      = start_ff;
      row_in        = row_ff;
      cur_in        = cur_ff;
      eidx_in       = eidx_ff;
      s1_v_in       = issue;
      s2_v_in       = cand;
      s2_node_in    = nbr;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_widx_in   = rsp_widx_ff;
      rsp_bits_in   = rsp_bits_ff;
      rsp_last_in   = rsp_last_ff;

      edge_wr_en    = 1'b0;
      edge_wr_addr  = edge_total_ff[EA_W-1:0];
      edge_wr_data  = {req_ch.end_a, req_ch.end_b};
      edge_rd_addr  = eidx_ff[EA_W-1:0];

      vis_wr_en     = 1'b0;
      vis_wr_addr   = row_ff;
      vis_wr_data   = '0;
      vis_rd_addr   = row_ff;

      stk_wr_en     = 1'b0;
      stk_wr_addr   = depth_ff[SA_W-1:0];
      stk_wr_data   = s2_node_ff;
      stk_rd_addr   = pop_idx[SA_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.operation)
                  OP_CLEAR: begin
                     edge_total_in = '0;
                     status_in     = STAT_OK;
                     state_in      = S_RESULT;
                  end
                  OP_APPEND: begin
                     // range check wins over the full check
                     if ((NCOUNT_W'(req_ch.end_a) >= n_eff) ||
                         (NCOUNT_W'(req_ch.end_b) >= n_eff)) begin
                        status_in = STAT_RANGE;
                     end else if (edge_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        edge_wr_en    = 1'b1;
                        edge_total_in = edge_total_ff + ET_W'(1);
                        status_in     = STAT_OK;
                     end
                     state_in = S_RESULT;
                  end
                  OP_SEARCH: begin
                     if (NCOUNT_W'(req_ch.start_node) >= n_eff) begin
                        status_in = STAT_RANGE;
                        state_in  = S_RESULT;
                     end else begin
                        start_in = req_ch.start_node;
                        row_in   = '0;
                        state_in = S_CLEAR;
                     end
                  end
                  default: begin
                     // unused operation: no state change, no response
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_widx_in   = '0;
               rsp_bits_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_CLEAR: begin
            // zero one visited row per cycle
            vis_wr_en = 1'b1;
            if (row_ff == RW'(ROWS - 1)) begin
               state_in = S_SEED;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end
         S_SEED: begin
            // rows are clear, so the start row is just its own bit
            vis_wr_en   = 1'b1;
            vis_wr_addr = RW'(start_ff[NODE_W-1:WORD_SHIFT]);
            vis_wr_data = WORD_W'(1) << start_ff[WORD_SHIFT-1:0];
            stk_wr_en   = 1'b1;
            stk_wr_addr = '0;
            stk_wr_data = start_ff;
            depth_in    = SD_W'(1);
            state_in    = S_POP;
         end
         S_POP: begin
            if (depth_ff == '0) begin
               row_in   = '0;
               state_in = S_OUT_RD;
            end else begin
               depth_in = pop_idx;
               state_in = S_CUR;
            end
         end
         S_CUR: begin
            cur_in  = stk_rd_data;
            eidx_in = '0;
            if (edge_total_ff == '0) begin
               state_in = S_POP;
            end else begin
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            if (issue) begin
               eidx_in = eidx_ff + ET_W'(1);
            end
            vis_rd_addr = RW'(nbr[NODE_W-1:WORD_SHIFT]);
            if (push) begin
               vis_wr_en   = 1'b1;
               vis_wr_addr = RW'(s2_node_ff[NODE_W-1:WORD_SHIFT]);
               vis_wr_data = vis_rd_data | (WORD_W'(1) << s2_node_ff[WORD_SHIFT-1:0]);
               stk_wr_en   = 1'b1;
               depth_in    = depth_ff + SD_W'(1);
            end
            // leave once the pipe has drained
            if (!issue && !s1_v_ff && !s2_v_ff) begin
               state_in = S_POP;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_WR;
         end
         S_OUT_WR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_widx_in   = WIDX_W'(row_ff);
               rsp_bits_in   = vis_rd_data & tail_mask;
               rsp_last_in   = word_last;
               if (word_last) begin
                  state_in = S_IDLE;
               end else begin
                  row_in   = row_ff + RW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         edge_total_ff <= '0;
         depth_ff      <= '0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         edge_total_ff <= edge_total_in;
         depth_ff      <= depth_in;
         s1_v_ff       <= s1_v_in;
         s2_v_ff       <= s2_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      start_ff      <= start_in;
      row_ff        <= row_in;
      cur_ff        <= cur_in;
      eidx_ff       <= eidx_in;
      s2_node_ff    <= s2_node_in;
      rsp_status_ff <= rsp_status_in;
      rsp_widx_ff   <= rsp_widx_in;
      rsp_bits_ff   <= rsp_bits_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.word_index   = rsp_widx_ff;
   assign rsp_ch.reached_bits = rsp_bits_ff;
   assign rsp_ch.last         = rsp_last_ff;

`ifndef SYNTH
   // only nodes inside the active range ever land on the stack
   a_push_in_range: assert property (@(posedge clock) disable iff (reset)
      push |-> (NCOUNT_W'(s2_node_ff) < n_eff))
      else $error("pushed node outside active node range");

   // seeding leaves exactly the start node on the stack
   a_seed_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEED) |=> (depth_ff == SD_W'(1)))
      else $error("stack depth wrong after seeding");

   // the final bitmap word ends the search and is marked last
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT_WR && out_free && word_last) |=>
         (state_ff == S_IDLE && rsp_ch.valid && rsp_ch.last))
      else $error("final bitmap word not closing the search");
`endif

endmodule
